// ===== rtl/core/sukt_pkg.sv =====
package sukt_pkg;

  localparam int unsigned KEY_W = 34;
  localparam int unsigned PAY_W = 32;
  localparam int unsigned POS_W = 4;
  localparam int unsigned CNT_OUT_W = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } sukt_cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } sukt_state_e;

  // broadcast to every cell during the execute cycle
  typedef struct packed {
    logic             ins_en;
    logic             rem_en;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } sukt_ctrl_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } sukt_stat_t;

endpackage

// ===== rtl/core/sukt_if.sv =====
interface sukt_req_if;
  import sukt_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       cmd;
  logic [KEY_W-1:0] entry_key;
  logic [PAY_W-1:0] entry_payload;

  modport source (output valid, output cmd, output entry_key, output entry_payload,
                  input ready);
  modport sink (input valid, input cmd, input entry_key, input entry_payload,
                output ready);
endinterface

interface sukt_rsp_if;
  import sukt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [PAY_W-1:0]     found_payload;
  logic [POS_W-1:0]     position;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source (output valid, output ok, output found_payload, output position,
                  output entry_count, input ready);
  modport sink (input valid, input ok, input found_payload, input position,
                input entry_count, output ready);
endinterface

// ===== rtl/core/sukt_cell.sv =====
module sukt_cell (
  input  logic                     clk_i,
  input  sukt_pkg::sukt_ctrl_t     ctrl_i,
  input  logic                     occ_i,
  input  logic                     prev_lt_i,
  input  logic [sukt_pkg::KEY_W-1:0] prev_key_i,
  input  logic [sukt_pkg::PAY_W-1:0] prev_pay_i,
  input  logic [sukt_pkg::KEY_W-1:0] next_key_i,
  input  logic [sukt_pkg::PAY_W-1:0] next_pay_i,
  output logic [sukt_pkg::KEY_W-1:0] key_o,
  output logic [sukt_pkg::PAY_W-1:0] pay_o,
  output sukt_pkg::sukt_stat_t     stat_o
);
  import sukt_pkg::*;

  logic [KEY_W-1:0] key_q, key_d;
  logic [PAY_W-1:0] pay_q, pay_d;
  logic             lt;

  assign lt         = occ_i && (key_q < ctrl_i.key);
  assign stat_o.lt  = lt;
  assign stat_o.eq  = occ_i && (key_q == ctrl_i.key);
  assign key_o      = key_q;
  assign pay_o      = pay_q;

  // cells below the sorted slot hold; the rest shift toward their neighbor
  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    if (ctrl_i.ins_en && !lt) begin
      if (prev_lt_i) begin
        key_d = ctrl_i.key;
        pay_d = ctrl_i.payload;
      end else begin
        key_d = prev_key_i;
        pay_d = prev_pay_i;
      end
    end else if (ctrl_i.rem_en && !lt) begin
      key_d = next_key_i;
      pay_d = next_pay_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

endmodule

// ===== rtl/core/sorted_unique_key_table_top.sv =====
// An accepted item is registered, executed in the execute state and its result held
// in the output register; a new item is taken only when idle. The execute cycle
// compares the key in every cell in parallel and shifts the cells from the slot
// onward by one place in the same edge. A result held in the output register stalls
// only the execute cycle. Reset clears the entry count and handshake state;
// key and payload cells are not cleared and are only read below the entry count.
module sorted_unique_key_table_top #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sukt_req_if.sink   req_i,
  sukt_rsp_if.source rsp_o
);
  import sukt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  sukt_state_e      state_q, state_d;
  sukt_cmd_e        cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [PAY_W-1:0] pay_q;
  logic [CNT_W-1:0] count_q, count_d;

  logic                 out_valid_q;
  logic                 out_ok_q;
  logic [PAY_W-1:0]     out_pay_q;
  logic [POS_W-1:0]     out_pos_q;
  logic [CNT_OUT_W-1:0] out_cnt_q;

  logic       req_fire, exec_fire, out_free;
  sukt_ctrl_t ctrl;

  logic [KEY_W-1:0] cell_key [TABLE_DEPTH];
  logic [PAY_W-1:0] cell_pay [TABLE_DEPTH];
  sukt_stat_t       cell_stat [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt_vec, eq_vec;

  logic             hit, full;
  logic [IDX_W-1:0] slot_idx;
  logic [PAY_W-1:0] hit_pay;
  logic             res_ok;
  logic [PAY_W-1:0] res_pay;
  logic [IDX_W-1:0] res_pos;
  logic [IDX_W+POS_W-1:0]     pos_ext;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

  assign out_free  = !out_valid_q || rsp_o.ready;
  assign req_fire  = req_i.valid && req_i.ready;

  // ---------------- control FSM ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (req_i.valid) state_d = ST_EXEC;
      ST_EXEC: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = 1'b0;
    exec_fire   = 1'b0;
    case (state_q)
      ST_IDLE: req_i.ready = 1'b1;
      ST_EXEC: exec_fire = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      cmd_q <= sukt_cmd_e'(req_i.cmd);
      key_q <= req_i.entry_key;
      pay_q <= req_i.entry_payload;
    end
  end

  // ---------------- cell row ----------------
  assign full = (count_q == CNT_W'(TABLE_DEPTH));

  assign ctrl.key     = key_q;
  assign ctrl.payload = pay_q;
  assign ctrl.ins_en  = exec_fire && (cmd_q == CMD_INSERT) && !hit && !full;
  assign ctrl.rem_en  = exec_fire && (cmd_q == CMD_REMOVE) && hit;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic             prev_lt;
    logic [KEY_W-1:0] prev_key, next_key;
    logic [PAY_W-1:0] prev_pay, next_pay;

    if (i == 0) begin : g_first
      assign prev_lt  = 1'b1;
      assign prev_key = key_q;
      assign prev_pay = pay_q;
    end else begin : g_mid
      assign prev_lt  = cell_stat[i-1].lt;
      assign prev_key = cell_key[i-1];
      assign prev_pay = cell_pay[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign next_key = cell_key[i];
      assign next_pay = cell_pay[i];
    end else begin : g_inner
      assign next_key = cell_key[i+1];
      assign next_pay = cell_pay[i+1];
    end

    sukt_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (CNT_W'(i) < count_q),
      .prev_lt_i  (prev_lt),
      .prev_key_i (prev_key),
      .prev_pay_i (prev_pay),
      .next_key_i (next_key),
      .next_pay_i (next_pay),
      .key_o      (cell_key[i]),
      .pay_o      (cell_pay[i]),
      .stat_o     (cell_stat[i])
    );

    assign lt_vec[i] = cell_stat[i].lt;
    assign eq_vec[i] = cell_stat[i].eq;
  end

  // keys are sorted, so lt_vec is a thermometer and its edge is the slot
  always_comb begin
    slot_idx = '0;
    hit_pay  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!lt_vec[i] && ((i == 0) || lt_vec[(i == 0) ? 0 : i - 1])) begin
        slot_idx = slot_idx | IDX_W'(i);
      end
      if (eq_vec[i]) begin
        hit_pay = hit_pay | cell_pay[i];
      end
    end
  end

  assign hit = |eq_vec;

  always_comb begin
    res_ok  = 1'b0;
    res_pay = '0;
    res_pos = '0;
    count_d = count_q;
    case (cmd_q)
      CMD_INSERT: begin
        if (hit) begin
          res_pos = slot_idx;
        end else if (!full) begin
          res_ok  = 1'b1;
          res_pos = slot_idx;
          count_d = count_q + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          res_ok  = 1'b1;
          res_pos = slot_idx;
          count_d = count_q - CNT_W'(1);
        end
      end
      CMD_SEARCH: begin
        if (hit) begin
          res_ok  = 1'b1;
          res_pay = hit_pay;
          res_pos = slot_idx;
        end
      end
      CMD_CLEAR: begin
        res_ok  = 1'b1;
        count_d = '0;
      end
      default: ;
    endcase
  end

  assign pos_ext = {{POS_W{1'b0}}, res_pos};
  assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (exec_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_ok_q  <= res_ok;
      out_pay_q <= res_pay;
      out_pos_q <= pos_ext[POS_W-1:0];
      out_cnt_q <= cnt_ext[CNT_OUT_W-1:0];
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.ok            = out_ok_q;
  assign rsp_o.found_payload = out_pay_q;
  assign rsp_o.position      = out_pos_q;
  assign rsp_o.entry_count   = out_cnt_q;

  // ---------------- assertions ----------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_unique_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |-> $onehot0(eq_vec))
    else $error("key matched in more than one cell");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins_en |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow entry count");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> rsp_o.valid)
    else $error("executed item produced no result");

endmodule

// ===== bench/sorted_unique_key_table_top_test.sv =====
module sorted_unique_key_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sukt_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned N_RANDOM = 600;
  localparam int unsigned POOL_N = 24;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  localparam logic [KEY_W-1:0] PHONE_MAX = 34'd9999999999;

  typedef struct packed {
    sukt_cmd_e          cmd;
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   payload;
  } table_cmd_t;

  typedef struct packed {
    logic                 ok;
    logic [PAY_W-1:0]     found_payload;
    logic [POS_W-1:0]     position;
    logic [CNT_OUT_W-1:0] entry_count;
  } table_result_t;

  logic clk_i;
  logic rst_ni;

  sukt_req_if req_if ();
  sukt_rsp_if rsp_if ();

  sorted_unique_key_table_top #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  table_cmd_t    cmd_queue[$];
  table_result_t table_results[$];

  // shadow copy of the table contents
  logic [KEY_W-1:0] key_tab[DEPTH];
  logic [PAY_W-1:0] pay_tab[DEPTH];
  int unsigned      fill;

  int unsigned n_sent;
  int unsigned n_seen;
  int unsigned n_errors;
  int unsigned n_ins_ok;
  int unsigned n_rem_ok;
  int unsigned n_hits;
  int unsigned n_full;

  logic [KEY_W-1:0] key_pool[POOL_N];

  always #10 clk_i = ~clk_i;

  // updates the shadow table and returns the result the command must produce
  function automatic table_result_t table_apply(table_cmd_t c);
    int unsigned   slot;
    logic          hit;
    table_result_t r;
    r = '0;
    slot = 0;
    while (slot < fill && key_tab[slot] < c.key) slot++;
    hit = (slot < fill) && (key_tab[slot] == c.key);
    case (c.cmd)
      CMD_INSERT: begin
        if (hit) begin
          r.position = slot[POS_W-1:0];
        end else if (fill < DEPTH) begin
          for (int j = fill; j > int'(slot); j--) begin
            key_tab[j] = key_tab[j-1];
            pay_tab[j] = pay_tab[j-1];
          end
          key_tab[slot] = c.key;
          pay_tab[slot] = c.payload;
          fill++;
          r.ok = 1'b1;
          r.position = slot[POS_W-1:0];
          n_ins_ok++;
        end else begin
          n_full++;
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          for (int j = slot; j + 1 < int'(fill); j++) begin
            key_tab[j] = key_tab[j+1];
            pay_tab[j] = pay_tab[j+1];
          end
          fill--;
          r.ok = 1'b1;
          r.position = slot[POS_W-1:0];
          n_rem_ok++;
        end
      end
      CMD_SEARCH: begin
        if (hit) begin
          r.ok = 1'b1;
          r.found_payload = pay_tab[slot];
          r.position = slot[POS_W-1:0];
          n_hits++;
        end
      end
      default: begin
        fill = 0;
        r.ok = 1'b1;
      end
    endcase
    r.entry_count = fill[CNT_OUT_W-1:0];
    return r;
  endfunction

  // about 8 gaps per hundred draws, none while the count sits in the quiet window
  function automatic bit take_gap(int unsigned n);
    return !(n >= 200 && n < 330) && ($urandom_range(99, 0) < 8);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[KEY_W-1:0];
  endfunction

  task automatic push_cmd(sukt_cmd_e cmd, logic [KEY_W-1:0] key, logic [PAY_W-1:0] payload);
    table_cmd_t c;
    c.cmd = cmd;
    c.key = key;
    c.payload = payload;
    cmd_queue.push_back(c);
  endtask

  // request driver; the expected result is computed at the accepting edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.cmd <= CMD_INSERT;
      req_if.entry_key <= '0;
      req_if.entry_payload <= '0;
    end else begin
      table_cmd_t c;
      if (req_if.valid && req_if.ready) begin
        c.cmd = sukt_cmd_e'(req_if.cmd);
        c.key = req_if.entry_key;
        c.payload = req_if.entry_payload;
        table_results.push_back(table_apply(c));
        n_sent++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (cmd_queue.size() != 0 && !take_gap(n_sent)) begin
          c = cmd_queue.pop_front();
          req_if.valid <= 1'b1;
          req_if.cmd <= c.cmd;
          req_if.entry_key <= c.key;
          req_if.entry_payload <= c.payload;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      table_result_t want;
      table_result_t got;
      if (rsp_if.valid && rsp_if.ready) begin
        got.ok = rsp_if.ok;
        got.found_payload = rsp_if.found_payload;
        got.position = rsp_if.position;
        got.entry_count = rsp_if.entry_count;
        if (table_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("result %0d arrived with nothing outstanding", n_seen);
        end else begin
          want = table_results.pop_front();
          if (got.ok !== want.ok || got.found_payload !== want.found_payload ||
              got.position !== want.position || got.entry_count !== want.entry_count) begin
            n_errors++;
            if (n_errors <= 10)
              $display("result %0d mismatch (exp/got): ok %0b/%0b payload %h/%h", n_seen,
                       want.ok, got.ok, want.found_payload, got.found_payload,
                       " position %0d/%0d count %0d/%0d",
                       want.position, got.position, want.entry_count, got.entry_count);
          end
        end
        n_seen++;
      end
      rsp_if.ready <= !take_gap(n_seen);
    end
  end

  initial begin
    int unsigned r;
    sukt_cmd_e   cmd;
    logic [KEY_W-1:0] key;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.cmd = CMD_INSERT;
    req_if.entry_key = '0;
    req_if.entry_payload = '0;
    rsp_if.ready = 1'b0;
    fill = 0;
    n_sent = 0;
    n_seen = 0;
    n_errors = 0;
    n_ins_ok = 0;
    n_rem_ok = 0;
    n_hits = 0;
    n_full = 0;

    // directed: empty table, key extremes, duplicates, head and tail removal, full table
    push_cmd(CMD_SEARCH, 34'd5, '0);
    push_cmd(CMD_REMOVE, 34'd5, '0);
    push_cmd(CMD_INSERT, KEY_MAX, '0);
    push_cmd(CMD_INSERT, '0, '1);
    push_cmd(CMD_INSERT, '0, 32'h1234_5678);
    push_cmd(CMD_SEARCH, '0, '1);
    push_cmd(CMD_SEARCH, KEY_MAX, '0);
    push_cmd(CMD_INSERT, PHONE_MAX, 32'ha5a5_a5a5);
    push_cmd(CMD_REMOVE, '0, '0);
    // descending keys land at the front, shifting the whole row up each time
    for (int i = 0; i < 14; i++)
      push_cmd(CMD_INSERT, KEY_W'((14 - i) * 1000003), $urandom());
    push_cmd(CMD_INSERT, 34'd1, $urandom());
    push_cmd(CMD_INSERT, KEY_MAX, $urandom());
    push_cmd(CMD_REMOVE, KEY_MAX, '0);
    push_cmd(CMD_CLEAR, '0, '0);

    // random: mostly keys from a small pool so hits, duplicates and a full table occur
    key_pool[0] = '0;
    key_pool[1] = KEY_MAX;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 150 == 0)
        for (int p = 2; p < POOL_N; p++) key_pool[p] = rand_key();
      r = $urandom_range(99, 0);
      if (r < 45) cmd = CMD_INSERT;
      else if (r < 65) cmd = CMD_REMOVE;
      else if (r < 98) cmd = CMD_SEARCH;
      else cmd = CMD_CLEAR;
      if ($urandom_range(3, 0) != 0) key = key_pool[$urandom_range(POOL_N - 1, 0)];
      else key = rand_key();
      push_cmd(cmd, key, $urandom());
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_queue.size() != 0 || req_if.valid) @(posedge clk_i);
    while (table_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d commands, %0d results checked: %0d inserts, %0d removes, %0d search hits",
             n_sent, n_seen, n_ins_ok, n_rem_ok, n_hits);
    $display("%0d inserts refused on a full table, %0d mismatches", n_full, n_errors);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", table_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sorted_unique_key_table_top.f =====
rtl/core/sukt_pkg.sv
rtl/core/sukt_if.sv
rtl/core/sukt_cell.sv
rtl/core/sorted_unique_key_table_top.sv
bench/sorted_unique_key_table_top_test.sv
